/* rtl/core/sm3_pkg.sv */
// ----------------------------------------------------------------------------
// SM3 package
// Shared constants, types and round functions of the SM3 hash engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sm3_pkg;
  localparam int BLOCK_WORDS_DEF = 16;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] IV [8] = '{
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };
  localparam logic [31:0] T_LOW  = 32'h79CC4519;
  localparam logic [31:0] T_HIGH = 32'h9D8A7A87;
  localparam logic [7:0]  PAD_BYTE = 8'h80;

  // Classified word handed from front to back. The length is only
  // meaningful on a finishing word.
  typedef struct packed {
    logic [31:0] word;
    logic        finish;
    logic [63:0] len;
  } work_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] p0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] p1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction
endpackage
`default_nettype wire

/* rtl/core/sm3_if.sv */
// ----------------------------------------------------------------------------
// SM3 stream interfaces
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sm3_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] message_word;
  logic [2:0]  valid_bytes;
  logic        last_word;
  modport source (output valid, message_word, valid_bytes, last_word, input ready);
  modport sink (input valid, message_word, valid_bytes, last_word, output ready);
endinterface

interface sm3_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

/* rtl/core/sm3_front.sv */
// ----------------------------------------------------------------------------
// SM3 front end
// Accepts message words, applies byte padding, counts the bit length and
// hands classified words to the queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_front (
  input  wire logic          clk,
  input  wire logic          rst,
  sm3_in_if.sink             in_ch,
  output sm3_pkg::work_t     work,
  output logic               work_valid,
  input  wire logic          work_ready
);
  import sm3_pkg::*;

  logic [63:0] bit_length;
  logic [2:0]  nbytes;
  logic [31:0] mask;
  logic [31:0] pad_bit;
  logic        pend_pad;
  logic        handoff;

  always_comb begin
    nbytes = (!in_ch.last_word || in_ch.valid_bytes > 3'd4) ? 3'd4 : in_ch.valid_bytes;
    unique case (nbytes)
      3'd0:    mask = 32'h0;
      3'd1:    mask = 32'hff000000;
      3'd2:    mask = 32'hffff0000;
      3'd3:    mask = 32'hffffff00;
      default: mask = 32'hffffffff;
    endcase
    unique case (nbytes)
      3'd0:    pad_bit = {PAD_BYTE, 24'h0};
      3'd1:    pad_bit = {8'h0, PAD_BYTE, 16'h0};
      3'd2:    pad_bit = {16'h0, PAD_BYTE, 8'h0};
      3'd3:    pad_bit = {24'h0, PAD_BYTE};
      default: pad_bit = 32'h0;
    endcase
  end

  // A full last word needs a separate pad word; the input is held off for it.
  assign in_ch.ready = !pend_pad && work_ready;

  always_comb begin
    if (pend_pad) begin
      work_valid = 1'b1;
      work.word = {PAD_BYTE, 24'h0};
      work.finish = 1'b1;
      work.len = bit_length;
    end else begin
      work_valid = in_ch.valid;
      work.word = (in_ch.message_word & mask) | pad_bit;
      work.finish = in_ch.last_word && nbytes != 3'd4;
      work.len = bit_length + {58'd0, nbytes, 3'd0};
    end
  end

  assign handoff = work_valid && work_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_length <= '0;
      pend_pad <= 1'b0;
    end else if (handoff) begin
      if (pend_pad) begin
        pend_pad <= 1'b0;
        bit_length <= '0;
      end else if (in_ch.last_word && nbytes == 3'd4) begin
        pend_pad <= 1'b1;
        bit_length <= work.len;
      end else if (in_ch.last_word) begin
        bit_length <= '0;
      end else begin
        bit_length <= work.len;
      end
    end
  end

  assert property (@(posedge clk) disable iff (rst) pend_pad |-> !in_ch.ready)
    else $error("input accepted while pad word pending");
  assert property (@(posedge clk) disable iff (rst) pend_pad |-> work_valid)
    else $error("pending pad word not offered");
  assert property (@(posedge clk) disable iff (rst)
    (handoff && work.finish) |=> bit_length == '0)
    else $error("bit length not cleared after a message");
endmodule
`default_nettype wire

/* rtl/core/sm3_core.sv */
// ----------------------------------------------------------------------------
// SM3 back end
// Fills the block buffer, expands messages, runs 64 rounds, pads the tail
// and streams the digest.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_core #(
  parameter int BLOCK_WORDS = sm3_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [31:0]   q_word,
  input  wire logic          q_finish,
  input  wire logic [63:0]   q_len,
  input  wire logic          q_valid,
  output logic               q_ready,
  sm3_out_if.source          out_ch
);
  import sm3_pkg::*;
  localparam int IW = $clog2(BLOCK_WORDS);

  typedef enum logic [4:0] {
    S_FILL = 5'b00001,
    S_RUN  = 5'b00010,
    S_PAD  = 5'b00100,
    S_OUT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t        state;
  logic [31:0]   w [BLOCK_WORDS];
  logic [31:0]   v [8];
  logic [31:0]   cv [8];
  logic [IW:0]   fill;
  logic [5:0]    round;
  logic          finishing;
  logic          after_pad;
  logic [63:0]   len;
  logic [2:0]    oidx;
  logic [31:0]   wnew, wj, wj4, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
  logic [31:0]   push_w;
  logic          push;

  assign q_ready = (state == S_FILL);

  // Window of 16 words: w[0] is W[j]; the new word is appended each round.
  always_comb begin
    wnew = p1(w[0] ^ w[7] ^ rotl(w[13], 5'd15)) ^ rotl(w[3], 5'd7) ^ w[10];
    wj = w[0];
    wj4 = w[4];
    tj = (round < 6'd16) ? rotl(T_LOW, round[4:0]) : rotl(T_HIGH, round[4:0] - 5'd16);
    a12 = rotl(v[0], 5'd12);
    ss1 = rotl(a12 + v[4] + tj, 5'd7);
    ss2 = ss1 ^ a12;
    ff = (round < 6'd16) ? (v[0] ^ v[1] ^ v[2])
         : ((v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]));
    gg = (round < 6'd16) ? (v[4] ^ v[5] ^ v[6]) : ((v[4] & v[5]) | (~v[4] & v[6]));
    tt1 = ff + v[3] + ss2 + (wj ^ wj4);
    tt2 = gg + v[7] + ss1 + wj;
  end

  // Words written during padding: zeros, then the two length words.
  always_comb begin
    push = 1'b0;
    push_w = '0;
    if (state == S_FILL && q_valid) begin
      push = 1'b1;
      push_w = q_word;
    end else if (state == S_PAD) begin
      push = 1'b1;
      if (!after_pad && fill == (IW+1)'(BLOCK_WORDS - 2)) push_w = len[63:32];
      else if (!after_pad && fill == (IW+1)'(BLOCK_WORDS - 1)) push_w = len[31:0];
      else push_w = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      fill <= '0;
      round <= '0;
      finishing <= 1'b0;
      after_pad <= 1'b0;
      oidx <= '0;
      for (int i = 0; i < 8; i++) cv[i] <= IV[i];
    end else begin
      unique case (state)
        S_FILL, S_PAD: begin
          if (push) begin
            w[fill[IW-1:0]] <= push_w;
            if (state == S_FILL && q_finish) begin
              finishing <= 1'b1;
              len <= q_len;
              after_pad <= (fill[IW-1:0] == IW'(BLOCK_WORDS - 1)) ||
                           (fill[IW-1:0] == IW'(BLOCK_WORDS - 2));
            end
            if (fill == (IW+1)'(BLOCK_WORDS - 1)) begin
              fill <= '0;
              state <= S_RUN;
              round <= '0;
              for (int i = 0; i < 8; i++) v[i] <= cv[i];
            end else begin
              fill <= fill + 1'b1;
              if (state == S_FILL && q_finish) state <= S_PAD;
            end
          end
        end
        S_RUN: begin
          for (int i = 0; i < BLOCK_WORDS - 1; i++) w[i] <= w[i+1];
          w[BLOCK_WORDS-1] <= wnew;
          v[3] <= v[2]; v[2] <= rotl(v[1], 5'd9); v[1] <= v[0]; v[0] <= tt1;
          v[7] <= v[6]; v[6] <= rotl(v[5], 5'd19); v[5] <= v[4]; v[4] <= p0(tt2);
          round <= round + 1'b1;
          if (round == 6'd63) begin
            cv[0] <= cv[0] ^ tt1; cv[1] <= cv[1] ^ v[0];
            cv[2] <= cv[2] ^ rotl(v[1], 5'd9); cv[3] <= cv[3] ^ v[2];
            cv[4] <= cv[4] ^ p0(tt2); cv[5] <= cv[5] ^ v[4];
            cv[6] <= cv[6] ^ rotl(v[5], 5'd19); cv[7] <= cv[7] ^ v[6];
            if (!finishing) state <= S_FILL;
            else if (after_pad) begin
              after_pad <= 1'b0;
              state <= S_PAD;
            end else state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ch.ready) begin
            oidx <= oidx + 1'b1;
            if (oidx == 3'd7) begin
              state <= S_FILL;
              finishing <= 1'b0;
              for (int i = 0; i < 8; i++) cv[i] <= IV[i];
            end
          end
        end
        default: state <= S_FILL;
      endcase
    end
  end

  assign out_ch.valid = (state == S_OUT);
  assign out_ch.digest_word = cv[oidx];
  assign out_ch.digest_last = (oidx == 3'd7);

  assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && round == 6'd63 && !finishing) |=> state == S_FILL)
    else $error("plain block did not return to fill");
  assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(oidx))
    else $error("digest index moved while stalled");
  assert property (@(posedge clk) disable iff (rst)
    state == S_RUN |-> fill == '0)
    else $error("fill count not cleared during rounds");
endmodule
`default_nettype wire

/* rtl/core/sm3_hash_engine_unit.sv */
// ----------------------------------------------------------------------------
// SM3 hash engine
// Streaming SM3-256 over big-endian words with padding and digest output.
// ----------------------------------------------------------------------------
// A block is compressed after its sixteenth word is in, by the single
//   round unit that runs one round per cycle. The back end takes no new
//   words during its rounds; only the two-entry queue takes them then.
// A last word adds one or two padded blocks, then eight digest beats.
// Reset (synchronous, rst high) loads the IV and clears all counters.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_hash_engine_unit #(
  parameter int BLOCK_WORDS = sm3_pkg::BLOCK_WORDS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  sm3_in_if.sink     in_ch,
  sm3_out_if.source  out_ch
);
  import sm3_pkg::*;

  // Front end: byte masking, pad byte insertion and length counting. A full
  // last word is followed by a separate pad word, during which the input
  // is held off.
  work_t       fwork;
  logic        fvalid;

  // Two-entry queue between front and back. It lets the front take words
  // while the back runs its rounds, until both entries are occupied.
  work_t       q [QUEUE_DEPTH];
  logic [1:0]  qcount;
  logic        qrd, qwr, qwr_ptr, qrd_ptr;
  logic        q_ready;
  logic        qfull;

  assign qfull = (qcount == 2'(QUEUE_DEPTH));
  assign qwr = fvalid && !qfull;

  sm3_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .work       (fwork),
    .work_valid (fvalid),
    .work_ready (!qfull)
  );

  // The back end pulls one word per cycle while it is filling its block and the queue holds a word.
  assign qrd = (qcount != 2'd0) && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      qcount <= '0;
      qwr_ptr <= 1'b0;
      qrd_ptr <= 1'b0;
    end else begin
      if (qwr) qwr_ptr <= ~qwr_ptr;
      if (qrd) qrd_ptr <= ~qrd_ptr;
      qcount <= qcount + 2'(qwr) - 2'(qrd);
    end
  end

  always_ff @(posedge clk) begin
    if (qwr) begin
      q[qwr_ptr] <= fwork;
    end
  end

  sm3_core #(.BLOCK_WORDS(BLOCK_WORDS)) u_core (
    .clk      (clk),
    .rst      (rst),
    .q_word   (q[qrd_ptr].word),
    .q_finish (q[qrd_ptr].finish),
    .q_len    (q[qrd_ptr].len),
    .q_valid  (qcount != 2'd0),
    .q_ready  (q_ready),
    .out_ch   (out_ch)
  );

  assert property (@(posedge clk) disable iff (rst) qcount <= 2'(QUEUE_DEPTH))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) qfull |-> !in_ch.ready)
    else $error("input accepted while queue full");
  assert property (@(posedge clk) disable iff (rst) (qwr && !qrd && !qfull) |=>
    qcount == $past(qcount) + 2'd1)
    else $error("queue count lost a write");
endmodule
`default_nettype wire

/* bench/sm3_hash_engine_unit_tb.sv */
// ----------------------------------------------------------------------------
// SM3 hash engine testbench
// Streams messages of varied length into the engine, predicts every digest
// with an independent SM3 model, and compares the digest beats as they leave.
// ----------------------------------------------------------------------------
`default_nettype none
module sm3_hash_engine_unit_tb;
  import sm3_pkg::*;

  // Digest beat as it is expected on the output channel.
  typedef struct packed {
    logic [31:0] word;
    logic        last;
  } digest_beat_t;

  // Scoreboard: a software SM3 engine plus the queue of digest beats it
  // predicts. Every accepted input beat is fed to it in order.
  class sm3_digest_board;
    logic [31:0]  chain [8];
    logic [31:0]  blk [16];
    int unsigned  fill;
    logic [63:0]  msg_bits;
    digest_beat_t pending [$];
    int unsigned  mismatches;

    function new();
      mismatches = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) chain[i] = IV[i];
      fill = 0;
      msg_bits = '0;
    endfunction

    function logic [31:0] rol(logic [31:0] x, int n);
      n = n % 32;
      if (n == 0) return x;
      return (x << n) | (x >> (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [68];
      logic [31:0] a, b, c, d, e, f, g, h;
      logic [31:0] tj, a12, ss1, ss2, tt1, tt2, ff, gg, x;
      for (int j = 0; j < 16; j++) w[j] = blk[j];
      for (int j = 16; j < 68; j++) begin
        x = w[j-16] ^ w[j-9] ^ rol(w[j-3], 15);
        w[j] = x ^ rol(x, 15) ^ rol(x, 23) ^ rol(w[j-13], 7) ^ w[j-6];
      end
      {a, b, c, d, e, f, g, h} = {chain[0], chain[1], chain[2], chain[3],
                                  chain[4], chain[5], chain[6], chain[7]};
      for (int j = 0; j < 64; j++) begin
        if (j < 16) begin
          tj = rol(32'h79CC4519, j);
          ff = a ^ b ^ c;
          gg = e ^ f ^ g;
        end else begin
          tj = rol(32'h9D8A7A87, j - 16);
          ff = (a & b) | (a & c) | (b & c);
          gg = (e & f) | (~e & g);
        end
        a12 = rol(a, 12);
        ss1 = rol(a12 + e + tj, 7);
        ss2 = ss1 ^ a12;
        tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
        tt2 = gg + h + ss1 + w[j];
        d = c; c = rol(b, 9); b = a; a = tt1;
        h = g; g = rol(f, 19); f = e;
        e = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
      end
      chain[0] ^= a; chain[1] ^= b; chain[2] ^= c; chain[3] ^= d;
      chain[4] ^= e; chain[5] ^= f; chain[6] ^= g; chain[7] ^= h;
    endfunction

    function void append(logic [31:0] w);
      blk[fill] = w;
      fill++;
      if (fill == 16) begin
        compress();
        fill = 0;
      end
    endfunction

    // Notes one accepted input beat; a last word queues eight digest beats.
    function void note_word(logic [31:0] word, logic [2:0] nbytes, logic last);
      int unsigned n;
      logic [31:0] mask;
      digest_beat_t beat;
      n = (!last || nbytes > 4) ? 4 : nbytes;
      msg_bits += 64'(n * 8);
      if (!last) begin
        append(word);
        return;
      end
      if (n == 4) begin
        append(word);
        append(32'h8000_0000);
      end else begin
        mask = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
        append((word & mask) | (32'h80 << (24 - 8 * n)));
      end
      if (fill > 14) while (fill != 0) append(32'h0);
      while (fill < 14) append(32'h0);
      append(msg_bits[63:32]);
      append(msg_bits[31:0]);
      for (int k = 0; k < 8; k++) begin
        beat.word = chain[k];
        beat.last = (k == 7);
        pending.push_back(beat);
      end
      restart();
    endfunction

    // Compares one accepted digest beat with the oldest prediction.
    function void check_digest(logic [31:0] word, logic last);
      digest_beat_t exp_beat;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest beat: word %h last %b", word, last);
        return;
      end
      exp_beat = pending.pop_front();
      if (word !== exp_beat.word || last !== exp_beat.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("digest mismatch: expected %h/%b, got %h/%b",
                   exp_beat.word, exp_beat.last, word, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  sm3_in_if  in_ch ();
  sm3_out_if out_ch ();

  sm3_hash_engine_unit u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sm3_digest_board board;
  int unsigned cycle_count;
  int unsigned words_sent;
  bit          calm_phase;   // no idling on either side near the end
  bit          hold_request; // asks the receiver for one long stall
  bit          hold_done;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    board = new();
    in_ch.valid = 1'b0;
    in_ch.message_word = '0;
    in_ch.valid_bytes = '0;
    in_ch.last_word = 1'b0;
    out_ch.ready = 1'b0;
    rst = 1'b1;
    cycle_count = 0;
    words_sent = 0;
    calm_phase = 1'b0;
    hold_request = 1'b0;
    hold_done = 1'b0;
  end

  // Reset is held from the start and released once.
  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
  end

  // The scoreboard sees each beat that crosses either channel, sampled at
  // the edge where valid and ready are both high.
  always @(posedge clk) begin
    if (!rst) begin
      if (in_ch.valid && in_ch.ready)
        board.note_word(in_ch.message_word, in_ch.valid_bytes, in_ch.last_word);
      if (out_ch.valid && out_ch.ready)
        board.check_digest(out_ch.digest_word, out_ch.digest_last);
    end
  end

  // Receiver: random stall bursts, and one long stall on request so that
  // the engine backs up onto its input.
  initial begin
    int unsigned burst;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request && !hold_done) begin
        out_ch.ready <= 1'b0;
        burst = 0;
        while (burst < 400) begin
          @(posedge clk);
          burst++;
        end
        hold_done = 1'b1;
        out_ch.ready <= 1'b1;
      end else if (!calm_phase && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Offers one word and holds it until it is accepted. The sender idles in
  // random bursts beforehand unless the run is in its calm phase.
  task automatic send_word(input logic [31:0] word, input logic [2:0] nbytes,
                           input logic last);
    if (!calm_phase && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.message_word <= word;
    in_ch.valid_bytes <= nbytes;
    in_ch.last_word <= last;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
  endtask

  // Sends a message of whole words followed by a last word with the given
  // valid byte count. Middle words carry a random byte count, which the
  // engine must ignore.
  task automatic send_message(input int unsigned body_words,
                              input logic [2:0] tail_bytes);
    for (int i = 0; i < body_words; i++)
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    send_word($urandom, tail_bytes, 1'b1);
  endtask

  task automatic drop_valid();
    in_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Sender pause: waits for every predicted digest beat to drain.
  task automatic wait_drained();
    drop_valid();
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  // Stimulus.
  initial begin
    int unsigned body;
    @(negedge rst);
    @(posedge clk);

    // Directed: the empty message, all-zero and all-one words, tail byte
    // counts zero to four, six and seven, a tail that leaves no room for the
    // length (two padding blocks), a last word that completes a full block,
    // and ignored bits beyond the valid bytes.
    send_word(32'h0, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'h6162_6300, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h0, 3'd7, 1'b1);
    send_word(32'hffff_ffff, 3'd5, 1'b0);
    send_word(32'h1234_5678, 3'd2, 1'b1);
    send_message(13, 3'd4);
    send_message(14, 3'd0);
    send_message(15, 3'd6);
    wait_drained();

    // Long stall on the output while the sender keeps offering words.
    hold_request = 1'b1;
    send_message(40, 3'd3);
    send_message(2, 3'd4);
    while (!hold_done) begin
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b0);
    end
    send_word($urandom, 3'd1, 1'b1);
    wait_drained();

    // Random messages, mostly short, a few spanning two or three blocks.
    while (words_sent < 160) begin
      if (words_sent > 135) calm_phase = 1'b1;
      body = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40)
                                         : $urandom_range(0, 17);
      send_message(body, 3'($urandom_range(0, 7)));
    end
    calm_phase = 1'b1;
    drop_valid();
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);

    if (board.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog: far above the slowest correct run of this stimulus.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end
endmodule
`default_nettype wire

/* sim.f */
rtl/core/sm3_pkg.sv
rtl/core/sm3_if.sv
rtl/core/sm3_front.sv
rtl/core/sm3_core.sv
rtl/core/sm3_hash_engine_unit.sv
bench/sm3_hash_engine_unit_tb.sv
